// ===== hdl/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the FIFO page replacement block.
// ----------------------------------------------------------------------------
package fpr_pkg;

	localparam int CFG_W = 7;
	localparam int CNT_W = 32;

	typedef logic [CNT_W-1:0] count_t;

	// per-cell control from the sequencer; compare, mark_dirty and shift are broadcast
	typedef struct packed {
		logic occupied;
		logic compare;
		logic mark_dirty;
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// ===== hdl/fpr_if.sv =====
// ----------------------------------------------------------------------------
// fpr_if
// Valid/ready channels: access request, result, frame limit write.
// ----------------------------------------------------------------------------
interface fpr_req_if #(parameter int PAGE_BITS = 20);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;
	logic                 is_write;
	modport source (output valid, page_number, is_write, input ready);
	modport sink   (input valid, page_number, is_write, output ready);
endinterface

interface fpr_rsp_if #(parameter int PAGE_BITS = 20);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 page_read;
	logic                 writeback;
	logic [PAGE_BITS-1:0] victim_page;
	logic [31:0]          read_total;
	logic [31:0]          write_total;
	modport source (output valid, hit, page_read, writeback, victim_page, read_total,
		write_total, input ready);
	modport sink   (input valid, hit, page_read, writeback, victim_page, read_total,
		write_total, output ready);
endinterface

interface fpr_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/fpr_cell.sv =====
// ----------------------------------------------------------------------------
// fpr_cell
// One queue slot: page tag, dirty flag, registered tag match.
// ----------------------------------------------------------------------------
module fpr_cell
	import fpr_pkg::*;
#(
	parameter int PAGE_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic [PAGE_BITS-1:0] page,
	input  logic                 wr,
	input  logic [PAGE_BITS-1:0] nxt_tag,
	input  logic                 nxt_dirty,
	output logic [PAGE_BITS-1:0] tag,
	output logic                 dirty,
	output logic                 match
);

	logic [PAGE_BITS-1:0] tag_q;
	logic                 dirty_q;
	logic                 match_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			tag_q <= page;
		end else if (ctl.shift) begin
			tag_q <= nxt_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				dirty_q <= wr;
			end else if (ctl.shift) begin
				dirty_q <= nxt_dirty;
			end else if (ctl.mark_dirty && match_q) begin
				dirty_q <= 1'b1;
			end
			if (ctl.compare) begin
				match_q <= ctl.occupied && (tag_q == page);
			end
		end
	end

	assign tag   = tag_q;
	assign dirty = dirty_q;
	assign match = match_q;

endmodule

// ===== hdl/fifo_page_replacement.sv =====
// ----------------------------------------------------------------------------
// fifo_page_replacement
// FIFO page replacement with dirty tracking over a chain of frame cells.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one access item per handshake (page_number, is_write).
//   rsp  : one result item per access (hit, page_read, writeback,
//          victim_page, read_total, write_total).
//   cfg  : write of frames_in_use; 0 acts as 1, values above MAX_FRAMES
//          act as MAX_FRAMES. Always ready; write only while idle.
// Flow: the accept cycle compares the page against every cell and
//   registers the match; the ST_RES state then resolves hit or miss once
//   the output register is free, shifts the queue one cell toward the
//   head on eviction, loads the new tail and fills the output register.
//   One item at a time; the result item is offered once the resolve step
//   has filled the output register.
// Cell 0 holds the oldest page; the queue order is the cell order.
// Reset: empty queue, all dirty flags clear, totals zero, limit MAX_FRAMES.
// Stall: a pending result stays in the output register while the next
//   access is accepted and compared; its resolve step waits until the
//   output register frees up.
// ----------------------------------------------------------------------------
module fifo_page_replacement
	import fpr_pkg::*;
#(
	parameter int MAX_FRAMES = 64,
	parameter int PAGE_BITS  = 20
) (
	input  logic   clk,
	input  logic   arst_n,
	fpr_req_if.sink   req,
	fpr_rsp_if.source rsp,
	fpr_cfg_if.sink   cfg
);

	localparam int OCC_W = $clog2(MAX_FRAMES + 1);
	localparam int LIM_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

	typedef enum logic {ST_IDLE, ST_RES} state_t;

	state_t               state_q;
	logic [LIM_W-1:0]     limit_q;
	logic [OCC_W-1:0]     occ_q;
	logic [PAGE_BITS-1:0] page_s1;
	logic                 wr_s1;
	count_t               load_cnt_q;
	count_t               flush_cnt_q;

	logic                 out_valid_q;
	logic                 hit_q;
	logic                 wb_q;
	logic [PAGE_BITS-1:0] victim_q;

	cell_ctl_t            ctl    [MAX_FRAMES];
	logic [PAGE_BITS-1:0] tag    [MAX_FRAMES+1];
	logic                 dirty  [MAX_FRAMES+1];
	logic [MAX_FRAMES-1:0] match;
	logic [PAGE_BITS-1:0] cmp_page;

	logic                 accept;
	logic                 upd;
	logic                 hit;
	logic [LIM_W-1:0]     limit;
	logic [LIM_W-1:0]     occ_ext;
	logic                 evict;
	logic [OCC_W-1:0]     load_pos;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign upd      = (state_q == ST_RES) && (!out_valid_q || rsp.ready);
	assign hit      = |match;
	assign occ_ext  = LIM_W'(occ_q);
	assign evict    = !hit && (occ_ext >= limit);
	assign load_pos = evict ? occ_q - 1'b1 : occ_q;
	assign cmp_page = req.page_number;

	always_comb begin
		limit = limit_q;
		if (limit_q == '0) begin
			limit = LIM_W'(1);
		end else if (limit_q > LIM_W'(MAX_FRAMES)) begin
			limit = LIM_W'(MAX_FRAMES);
		end
	end

	assign tag[MAX_FRAMES]   = '0;
	assign dirty[MAX_FRAMES] = 1'b0;

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		always_comb begin
			ctl[i].occupied   = (OCC_W'(i) < occ_q);
			ctl[i].compare    = accept;
			ctl[i].mark_dirty = upd && hit && wr_s1;
			ctl[i].shift      = upd && evict;
			ctl[i].load       = upd && !hit && (load_pos == OCC_W'(i));
		end

		fpr_cell #(
			.PAGE_BITS (PAGE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.page      (accept ? cmp_page : page_s1),
			.wr        (wr_s1),
			.nxt_tag   (tag[i+1]),
			.nxt_dirty (dirty[i+1]),
			.tag       (tag[i]),
			.dirty     (dirty[i]),
			.match     (match[i])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1 <= req.page_number;
			wr_s1   <= req.is_write;
		end
		if (upd) begin
			hit_q    <= hit;
			wb_q     <= evict && dirty[0];
			victim_q <= evict ? tag[0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIM_W'(MAX_FRAMES);
			occ_q       <= '0;
			load_cnt_q  <= '0;
			flush_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= LIM_W'(cfg.data);
			end
			if (upd) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (upd) begin
						state_q <= ST_IDLE;
						if (!hit) begin
							if (load_cnt_q != '1) begin
								load_cnt_q <= load_cnt_q + 1'b1;
							end
							if (!evict) begin
								occ_q <= occ_q + 1'b1;
							end
							if (evict && dirty[0] && flush_cnt_q != '1) begin
								flush_cnt_q <= flush_cnt_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.page_read   = !hit_q;
	assign rsp.writeback   = wb_q;
	assign rsp.victim_page = victim_q;
	assign rsp.read_total  = load_cnt_q;
	assign rsp.write_total = flush_cnt_q;

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(MAX_FRAMES))
		else $error("occupancy above frame count");

	a_occ_mono: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RES && upd |=> occ_q >= $past(occ_q))
		else $error("occupancy dropped");

	a_wb_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.writeback |-> !rsp.hit)
		else $error("write-back reported on a hit");

	a_resolve_done: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> state_q == ST_IDLE && out_valid_q)
		else $error("resolve did not post a result");
`endif

endmodule
